[rtl/core/slotted_page_manager_assert.svh]
// Assertion macros for the slotted page manager RTL.
`ifndef SLOTTED_PAGE_MANAGER_ASSERT_SVH
`define SLOTTED_PAGE_MANAGER_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define SPM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define SPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/spm_pkg.sv]
// Types and constants of the slotted page manager.
package spm_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int SLOT_LIMIT   = 1024;
    // slot counter holds 0..SLOT_LIMIT
    localparam int SLOT_W       = 11;
    // working width for page arithmetic, enough for a 64 KiB page plus carry
    localparam int CALC_W       = 17;

    localparam logic [7:0] DELETED_BYTE = 8'hFF;

    localparam logic [2:0] OP_INSERT_START = 3'd0;
    localparam logic [2:0] OP_INSERT_BYTE  = 3'd1;
    localparam logic [2:0] OP_DELETE       = 3'd2;
    localparam logic [2:0] OP_READ_SIZE    = 3'd3;
    localparam logic [2:0] OP_READ_BYTE    = 3'd4;

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_NO_SPACE    = 3'd1;
    localparam logic [2:0] STATUS_INVALID     = 3'd2;
    localparam logic [2:0] STATUS_DELETED     = 3'd3;
    localparam logic [2:0] STATUS_NO_PENDING  = 3'd4;
    localparam logic [2:0] STATUS_INDEX_RANGE = 3'd5;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  assigned_slot;
        logic [11:0] row_offset;
        logic [11:0] result_value;
    } spm_result_t;

endpackage

[rtl/core/spm_page_ram.sv]
// Single-port byte memory holding the page image.
module spm_page_ram #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic                          aclk,
    input  logic                          mem_we,
    input  logic [$clog2(PAGE_BYTES)-1:0] mem_addr,
    input  logic [7:0]                    mem_wdata,
    output logic [7:0]                    mem_rdata
);
    logic [7:0] mem [PAGE_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    assign mem_rdata = rdata_reg;

endmodule

[rtl/core/spm_ctrl.sv]
// Sequencer: header counters, slot scan and byte-wise page accesses.
module spm_ctrl #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_op,
    input  logic [9:0]                    s_slot,
    input  logic [11:0]                   s_row_length,
    input  logic [7:0]                    s_byte_value,
    input  logic [11:0]                   s_byte_index,
    output logic                          res_valid,
    output spm_pkg::spm_result_t          res,
    input  logic                          out_free,
    output logic                          mem_we,
    output logic [$clog2(PAGE_BYTES)-1:0] mem_addr,
    output logic [7:0]                    mem_wdata,
    input  logic [7:0]                    mem_rdata
);
    import spm_pkg::*;

`include "slotted_page_manager_assert.svh"

    localparam int AW = $clog2(PAGE_BYTES);
    localparam int FW = AW + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_ALLOC,
        ST_W_INS,
        ST_W_DEL,
        ST_R_E3,
        ST_R_E0,
        ST_R_E1,
        ST_R_L0,
        ST_R_L1,
        ST_R_D,
        ST_R_DW,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        op_reg, op_next;
    logic [9:0]        slot_reg, slot_next;
    logic [11:0]       len_reg, len_next;
    logic [7:0]        bval_reg, bval_next;
    logic [11:0]       bidx_reg, bidx_next;
    logic [SLOT_W-1:0] slot_count_reg, slot_count_next;
    logic [FW-1:0]     free_start_reg, free_start_next;
    logic [FW-1:0]     free_end_reg, free_end_next;
    logic [AW-1:0]     fill_reg, fill_next;
    logic [11:0]       pend_reg, pend_next;
    logic [SLOT_W-1:0] scan_reg, scan_next;
    logic [AW-1:0]     row_off_reg, row_off_next;
    logic [7:0]        off_lo_reg, off_lo_next;
    logic [AW-1:0]     off_reg, off_next;
    logic [7:0]        rlen_lo_reg, rlen_lo_next;
    logic [2:0]        step_reg, step_next;
    spm_result_t       res_reg, res_next;

    logic [CALC_W-1:0] fs_w, fe_w, avail_w, need_w, new_fe_w, fill_w, ent_w, dat_w;
    logic [SLOT_W-1:0] ent_idx;
    logic [AW-1:0]     ent_addr;
    logic [15:0]       off_word, row_off_word;
    logic [11:0]       rlen;
    logic              slot_bad;

    // page arithmetic
    always_comb begin
        fs_w     = CALC_W'(free_start_reg);
        fe_w     = CALC_W'(free_end_reg);
        avail_w  = (fe_w >= fs_w) ? (fe_w - fs_w) : '0;
        need_w   = CALC_W'(len_reg) + CALC_W'(8);
        new_fe_w = fe_w - CALC_W'(len_reg) - CALC_W'(4);
        fill_w   = new_fe_w + CALC_W'(4);
        ent_idx  = (op_reg == OP_INSERT_START) ? scan_reg : {1'b0, slot_reg};
        ent_w    = CALC_W'(HEADER_BYTES) + {4'b0, ent_idx, 2'b00};
        ent_addr = ent_w[AW-1:0];
        off_word = {mem_rdata, off_lo_reg};
        row_off_word = 16'(row_off_reg);
        dat_w    = CALC_W'(off_reg) + CALC_W'(4) + CALC_W'(bidx_reg);
        rlen     = {mem_rdata[3:0], rlen_lo_reg};
        slot_bad = ({1'b0, slot_reg} >= slot_count_reg);
    end

    // memory port
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        unique case (state_reg)
            ST_DISPATCH: begin
                if (op_reg == OP_INSERT_BYTE && pend_reg != '0) begin
                    mem_we    = 1'b1;
                    mem_addr  = fill_reg;
                    mem_wdata = bval_reg;
                end
            end
            ST_SCAN_RD, ST_R_E3: mem_addr = ent_addr + AW'(3);
            ST_W_INS: begin
                mem_we = 1'b1;
                if (!step_reg[2]) begin
                    mem_addr = row_off_reg + AW'(step_reg[1:0]);
                    unique case (step_reg[1:0])
                        2'd0:    mem_wdata = len_reg[7:0];
                        2'd1:    mem_wdata = {4'b0, len_reg[11:8]};
                        default: mem_wdata = '0;
                    endcase
                end else begin
                    mem_addr = ent_addr + AW'(step_reg[1:0]);
                    unique case (step_reg[1:0])
                        2'd0:    mem_wdata = row_off_word[7:0];
                        2'd1:    mem_wdata = row_off_word[15:8];
                        default: mem_wdata = '0;
                    endcase
                end
            end
            ST_W_DEL: begin
                mem_we    = 1'b1;
                mem_addr  = ent_addr + AW'(step_reg[1:0]);
                mem_wdata = DELETED_BYTE;
            end
            ST_R_E0: mem_addr = ent_addr;
            ST_R_E1: mem_addr = ent_addr + AW'(1);
            ST_R_L0: mem_addr = off_word[AW-1:0];
            ST_R_L1: mem_addr = off_reg + AW'(1);
            ST_R_D:  mem_addr = dat_w[AW-1:0];
            default: mem_addr = '0;
        endcase
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        slot_next       = slot_reg;
        len_next        = len_reg;
        bval_next       = bval_reg;
        bidx_next       = bidx_reg;
        slot_count_next = slot_count_reg;
        free_start_next = free_start_reg;
        free_end_next   = free_end_reg;
        fill_next       = fill_reg;
        pend_next       = pend_reg;
        scan_next       = scan_reg;
        row_off_next    = row_off_reg;
        off_lo_next     = off_lo_reg;
        off_next        = off_reg;
        rlen_lo_next    = rlen_lo_reg;
        step_next       = step_reg;
        res_next        = res_reg;
        s_ready         = 1'b0;
        res_valid       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = s_op;
                    slot_next  = s_slot;
                    len_next   = s_row_length;
                    bval_next  = s_byte_value;
                    bidx_next  = s_byte_index;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                res_next   = '0;
                state_next = ST_DONE;
                unique case (op_reg)
                    OP_INSERT_START: begin
                        scan_next = '0;
                        if (avail_w < need_w) begin
                            res_next.status = STATUS_NO_SPACE;
                        end else if (slot_count_reg == '0) begin
                            state_next = ST_ALLOC;
                        end else begin
                            state_next = ST_SCAN_RD;
                        end
                    end
                    OP_INSERT_BYTE: begin
                        if (pend_reg == '0) begin
                            res_next.status = STATUS_NO_PENDING;
                        end else begin
                            fill_next = fill_reg + AW'(1);
                            pend_next = pend_reg - 12'd1;
                        end
                    end
                    OP_DELETE, OP_READ_SIZE, OP_READ_BYTE: begin
                        step_next = '0;
                        if (slot_bad) begin
                            res_next.status = STATUS_INVALID;
                        end else if (op_reg == OP_DELETE) begin
                            state_next = ST_W_DEL;
                        end else begin
                            state_next = ST_R_E3;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_SCAN_RD: state_next = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                // only deleted entries carry 0xFF in their top byte
                if (mem_rdata == DELETED_BYTE) begin
                    state_next = ST_ALLOC;
                end else if (scan_reg + SLOT_W'(1) == slot_count_reg) begin
                    scan_next  = slot_count_reg;
                    state_next = ST_ALLOC;
                end else begin
                    scan_next  = scan_reg + SLOT_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_ALLOC: begin
                if (scan_reg >= SLOT_W'(SLOT_LIMIT)) begin
                    res_next.status = STATUS_NO_SPACE;
                    state_next      = ST_DONE;
                end else begin
                    free_end_next = new_fe_w[FW-1:0];
                    row_off_next  = new_fe_w[AW-1:0];
                    fill_next     = fill_w[AW-1:0];
                    pend_next     = len_reg;
                    if (scan_reg == slot_count_reg) begin
                        slot_count_next = slot_count_reg + SLOT_W'(1);
                        free_start_next = free_start_reg + FW'(4);
                    end
                    res_next.assigned_slot = scan_reg[9:0];
                    res_next.row_offset    = new_fe_w[11:0];
                    step_next              = '0;
                    state_next             = ST_W_INS;
                end
            end
            ST_W_INS: begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7) begin
                    state_next = ST_DONE;
                end
            end
            ST_W_DEL: begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3) begin
                    state_next = ST_DONE;
                end
            end
            ST_R_E3: state_next = ST_R_E0;
            ST_R_E0: begin
                if (mem_rdata == DELETED_BYTE) begin
                    res_next.status = STATUS_DELETED;
                    state_next      = ST_DONE;
                end else begin
                    state_next = ST_R_E1;
                end
            end
            ST_R_E1: begin
                off_lo_next = mem_rdata;
                state_next  = ST_R_L0;
            end
            ST_R_L0: begin
                off_next   = off_word[AW-1:0];
                state_next = ST_R_L1;
            end
            ST_R_L1: begin
                rlen_lo_next = mem_rdata;
                state_next   = ST_R_D;
            end
            ST_R_D: begin
                state_next = ST_DONE;
                if (op_reg == OP_READ_SIZE) begin
                    res_next.result_value = rlen;
                end else if (bidx_reg >= rlen) begin
                    res_next.status = STATUS_INDEX_RANGE;
                end else begin
                    state_next = ST_R_DW;
                end
            end
            ST_R_DW: begin
                res_next.result_value = {4'b0, mem_rdata};
                state_next            = ST_DONE;
            end
            ST_DONE: begin
                res_valid = out_free;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slot_count_reg <= '0;
            free_start_reg <= FW'(HEADER_BYTES);
            free_end_reg   <= FW'(PAGE_BYTES);
            fill_reg       <= '0;
            pend_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            slot_count_reg <= slot_count_next;
            free_start_reg <= free_start_next;
            free_end_reg   <= free_end_next;
            fill_reg       <= fill_next;
            pend_reg       <= pend_next;
        end
        op_reg      <= op_next;
        slot_reg    <= slot_next;
        len_reg     <= len_next;
        bval_reg    <= bval_next;
        bidx_reg    <= bidx_next;
        scan_reg    <= scan_next;
        row_off_reg <= row_off_next;
        off_lo_reg  <= off_lo_next;
        off_reg     <= off_next;
        rlen_lo_reg <= rlen_lo_next;
        step_reg    <= step_next;
        res_reg     <= res_next;
    end

    assign res = res_reg;

    `SPM_ASSERT_IMPL(a_res_into_free_reg, res_valid, out_free, "result beat with output busy")
    `SPM_ASSERT_IMPL(a_no_write_when_idle, s_ready, !mem_we, "page write while idle")
    `SPM_ASSERT_IMPL(a_free_gap_order, 1'b1, free_start_reg <= free_end_reg, "free gap inverted")
    `SPM_ASSERT_IMPL(a_alloc_slot_range, state_reg == ST_W_INS, scan_reg < SLOT_W'(SLOT_LIMIT), "slot beyond limit written")

endmodule

[rtl/core/slotted_page_manager.sv]
// Top level of the slotted page manager: sequencer, page memory, result register.
//
// Manages one slotted page in a single-port byte RAM (one access per cycle,
// registered read data); slot count and free pointers sit in registers
// and reset formats the page without touching the RAM. One item is worked at
// a time. insert_byte and any item answered from the header alone finish
// straight after dispatch. insert_start visits one slot directory entry after
// another while looking for the lowest deleted slot (the scan stops at the
// first one), so its time is bounded by the slot count; it fails before the
// scan when the gap is too small. Every page access goes byte-wise through
// the one RAM port. The result beat sits in an output register, so a stalled
// result does not hold up the next item's work.
module slotted_page_manager #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [9:0]  s_slot,
    input  logic [11:0] s_row_length,
    input  logic [7:0]  s_byte_value,
    input  logic [11:0] s_byte_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [9:0]  m_assigned_slot,
    output logic [11:0] m_row_offset,
    output logic [11:0] m_result_value
);
    import spm_pkg::*;

    localparam int AW = $clog2(PAGE_BYTES);

    logic          res_valid;
    spm_result_t   res;
    logic          out_free;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    logic          m_valid_reg;
    spm_result_t   m_res_reg;

    spm_ctrl #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_slot      (s_slot),
        .s_row_length(s_row_length),
        .s_byte_value(s_byte_value),
        .s_byte_index(s_byte_index),
        .res_valid   (res_valid),
        .res         (res),
        .out_free    (out_free),
        .mem_we      (mem_we),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .mem_rdata   (mem_rdata)
    );

    spm_page_ram #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_ram (
        .aclk     (aclk),
        .mem_we   (mem_we),
        .mem_addr (mem_addr),
        .mem_wdata(mem_wdata),
        .mem_rdata(mem_rdata)
    );

    // output register: free when empty or when its beat leaves this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_res_reg.status;
    assign m_assigned_slot = m_res_reg.assigned_slot;
    assign m_row_offset    = m_res_reg.row_offset;
    assign m_result_value  = m_res_reg.result_value;

endmodule

[test/slotted_page_manager_tb.sv]
// Self-checking testbench for the slotted page manager: directed cases, random traffic, full page.
module slotted_page_manager_tb;
    import spm_pkg::*;

    localparam int PAGE_BYTES    = 4096;
    localparam int MAX_GAP       = 6;     // longest random wait on either side, in cycles
    localparam int STALL_LIMIT   = 5000;  // idle cycles before the watchdog fires
    localparam int TAIL_CYCLES   = 32;    // settle time after the last result beat
    localparam int REPORT_LIMIT  = 10;    // mismatches printed in full
    localparam int RANDOM_TARGET = 880;   // request beats (with a result) before the full-page test
    localparam int GAP_STRETCH   = 150;   // beats per stretch with or without idle cycles

    // Op codes 5..7 are undefined: the block accepts them and answers nothing.
    localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;
    localparam logic [31:0] DELETED_WORD   = {4{DELETED_BYTE}};

    typedef struct packed {
        logic [2:0]  op;
        logic [9:0]  slot;
        logic [11:0] row_length;
        logic [7:0]  byte_value;
        logic [11:0] byte_index;
    } page_req_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic [2:0]  s_op           = OP_INSERT_START;
    logic [9:0]  s_slot         = '0;
    logic [11:0] s_row_length   = '0;
    logic [7:0]  s_byte_value   = '0;
    logic [11:0] s_byte_index   = '0;
    logic        m_ready        = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [2:0]  m_status;
    logic [9:0]  m_assigned_slot;
    logic [11:0] m_row_offset;
    logic [11:0] m_result_value;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    slotted_page_manager #(
        .PAGE_BYTES(PAGE_BYTES)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_slot         (s_slot),
        .s_row_length   (s_row_length),
        .s_byte_value   (s_byte_value),
        .s_byte_index   (s_byte_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_assigned_slot(m_assigned_slot),
        .m_row_offset   (m_row_offset),
        .m_result_value (m_result_value)
    );

    // ------------------------------------------------------------------
    // Page image kept by the testbench. Header counters are plain ints;
    // page_written marks bytes that hold defined data, so that stimulus
    // never reads a row byte that was not filled.
    // ------------------------------------------------------------------
    logic [7:0]  page_img     [PAGE_BYTES];
    bit          page_written [PAGE_BYTES];
    int unsigned slot_total = 0;
    int unsigned free_lo    = HEADER_BYTES;
    int unsigned free_hi    = PAGE_BYTES;
    int unsigned fill_at    = 0;
    int unsigned fill_left  = 0;

    spm_result_t expected_results[$];

    bit gaps_on      = 1'b1;  // random idle cycles on both sides
    bit result_taken = 1'b0;  // a result beat was accepted at the last rising edge
    int hold_cycles  = 0;
    int idle_cycles  = 0;
    int error_count  = 0;
    int beats_sent   = 0;
    int results_seen = 0;
    int rows_stored  = 0;
    int rows_refused = 0;

    function automatic int unsigned entry_of(input int unsigned s);
        return HEADER_BYTES + 4 * s;
    endfunction

    // Little-endian word, addresses wrap at the page size.
    function automatic logic [31:0] word_at(input int unsigned a);
        return {page_img[(a + 3) % PAGE_BYTES], page_img[(a + 2) % PAGE_BYTES],
                page_img[(a + 1) % PAGE_BYTES], page_img[a % PAGE_BYTES]};
    endfunction

    function automatic void put_word(input int unsigned a, input logic [31:0] w);
        for (int k = 0; k < 4; k++) begin
            page_img[(a + k) % PAGE_BYTES]     = w[8*k +: 8];
            page_written[(a + k) % PAGE_BYTES] = 1'b1;
        end
    endfunction

    // Applies one request to the page image. Returns 0 for the undefined
    // op codes, which leave no result behind.
    function automatic bit predict_page(input page_req_t r, output spm_result_t res);
        int unsigned gap;
        int unsigned pick;
        int unsigned off;
        int unsigned rlen;
        res = '0;
        if (r.op > OP_READ_BYTE)
            return 1'b0;
        if (r.op == OP_INSERT_START) begin
            gap  = free_hi >= free_lo ? free_hi - free_lo : 0;
            pick = slot_total;
            // downward pass leaves the lowest deleted slot in pick
            for (int i = int'(slot_total) - 1; i >= 0; i--)
                if (word_at(entry_of(i)) == DELETED_WORD)
                    pick = i;
            // the slot entry's 4 bytes count even when a slot is reused
            if (gap < 32'(r.row_length) + 8 || pick >= SLOT_LIMIT) begin
                res.status = STATUS_NO_SPACE;
                rows_refused++;
            end else begin
                free_hi -= 32'(r.row_length) + 4;
                put_word(free_hi, 32'(r.row_length));
                put_word(entry_of(pick), free_hi);
                if (pick == slot_total) begin
                    slot_total++;
                    free_lo += 4;
                end
                fill_at            = free_hi + 4;   // abandons any row still being filled
                fill_left          = r.row_length;
                res.assigned_slot  = 10'(pick);
                res.row_offset     = 12'(free_hi);
                rows_stored++;
            end
        end else if (r.op == OP_INSERT_BYTE) begin
            if (fill_left == 0) begin
                res.status = STATUS_NO_PENDING;
            end else begin
                page_img[fill_at % PAGE_BYTES]     = r.byte_value;
                page_written[fill_at % PAGE_BYTES] = 1'b1;
                fill_at++;
                fill_left--;
            end
        end else if (32'(r.slot) >= slot_total) begin
            res.status = STATUS_INVALID;
        end else if (r.op == OP_DELETE) begin
            put_word(entry_of(r.slot), DELETED_WORD);  // deleting twice is fine
        end else begin
            off = word_at(entry_of(r.slot));
            if (off == DELETED_WORD) begin
                res.status = STATUS_DELETED;
            end else begin
                rlen = word_at(off);
                if (r.op == OP_READ_SIZE)
                    res.result_value = 12'(rlen);
                else if (32'(r.byte_index) >= rlen)
                    res.status = STATUS_INDEX_RANGE;
                else
                    res.result_value = 12'(page_img[(off + 4 + r.byte_index) % PAGE_BYTES]);
            end
        end
        return 1'b1;
    endfunction

    // Keeps read_byte away from row bytes that were never filled: such an
    // index is moved to the row length, which answers index past row.
    function automatic logic [11:0] safe_index(input logic [9:0] s, input logic [11:0] idx);
        int unsigned off;
        int unsigned rlen;
        if (32'(s) >= slot_total)
            return idx;
        off = word_at(entry_of(s));
        if (off == DELETED_WORD)
            return idx;
        rlen = word_at(off);
        if (32'(idx) >= rlen || page_written[(off + 4 + idx) % PAGE_BYTES])
            return idx;
        return 12'(rlen);
    endfunction

    function automatic page_req_t request(input logic [2:0] op, input logic [9:0] slot,
                                          input logic [11:0] row_length,
                                          input logic [7:0] byte_value,
                                          input logic [11:0] byte_index);
        page_req_t r;
        r.op         = op;
        r.slot       = slot;
        r.row_length = row_length;
        r.byte_value = byte_value;
        r.byte_index = byte_index;
        return r;
    endfunction

    // Unused fields carry random junk as well.
    function automatic page_req_t random_fields(input logic [2:0] op);
        return request(op, 10'($urandom_range(0, 1023)), 12'($urandom_range(0, 4095)),
                       8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
    endfunction

    // Delete or read aimed mostly at live slots, sometimes one past the
    // last slot or anywhere in the 10-bit range.
    function automatic page_req_t random_lookup(input logic [2:0] op);
        page_req_t r;
        r = random_fields(op);
        if (slot_total != 0 && $urandom_range(0, 9) != 0)
            r.slot = 10'($urandom_range(0, slot_total));
        if ($urandom_range(0, 9) != 0)
            r.byte_index = 12'($urandom_range(0, 12));
        r.byte_index = safe_index(r.slot, r.byte_index);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side. Drives on the falling edge; valid is only dropped when
    // a wait is drawn, so back-to-back beats keep it high.
    // ------------------------------------------------------------------
    task automatic send_request(input page_req_t r);
        int gap;
        spm_result_t outcome;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= r.op;
        s_slot       <= r.slot;
        s_row_length <= r.row_length;
        s_byte_value <= r.byte_value;
        s_byte_index <= r.byte_index;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (predict_page(r, outcome)) begin
            expected_results.push_back(outcome);
            beats_sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: ready held low for a random number of cycles per beat.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (result_taken)
            hold_cycles = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (hold_cycles != 0) begin
            m_ready <= 1'b0;
            hold_cycles--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Each result beat against the oldest expectation.
    always @(posedge aclk) begin : result_check
        spm_result_t seen;
        spm_result_t want;
        result_taken = aresetn && m_valid && m_ready;
        if (result_taken) begin
            seen.status        = m_status;
            seen.assigned_slot = m_assigned_slot;
            seen.row_offset    = m_row_offset;
            seen.result_value  = m_result_value;
            results_seen++;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("Unexpected result beat: status %0d slot %0d offset %0d value %0d",
                             seen.status, seen.assigned_slot, seen.row_offset,
                             seen.result_value);
            end else begin
                want = expected_results.pop_front();
                if (seen.status !== want.status || seen.assigned_slot !== want.assigned_slot ||
                    seen.row_offset !== want.row_offset ||
                    seen.result_value !== want.result_value) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $write("Result %0d: expected status %0d slot %0d offset %0d value %0d, ",
                               results_seen, want.status, want.assigned_slot, want.row_offset,
                               want.result_value);
                        $display("got status %0d slot %0d offset %0d value %0d",
                                 seen.status, seen.assigned_slot, seen.row_offset,
                                 seen.result_value);
                    end
                end
            end
        end
    end

    // Watchdog: an insert that scans a long slot directory is the slowest
    // item, and still well under the limit.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no beat accepted for %0d cycles", idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fresh page: nothing to read, delete or fill; oversized row refused.
    task automatic test_empty_page();
        send_request(request(OP_READ_SIZE, 10'd0, 12'd0, 8'd0, 12'd0));
        send_request(request(OP_READ_BYTE, 10'h3FF, 12'hFFF, 8'hFF, 12'hFFF));
        send_request(request(OP_DELETE, 10'd0, 12'd0, 8'd0, 12'd0));
        send_request(request(OP_INSERT_BYTE, 10'h3FF, 12'hFFF, 8'hFF, 12'hFFF));
        for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
            send_request(request(3'(c), 10'h3FF, 12'hFFF, 8'hFF, 12'hFFF));
        send_request(request(OP_INSERT_START, 10'd0, 12'hFFF, 8'd0, 12'd0));
    endtask

    // Empty row and a short row; read back, past-row index, slot one past the end.
    task automatic test_insert_and_read();
        send_request(request(OP_INSERT_START, 10'h3FF, 12'd0, 8'd0, 12'd0));
        send_request(request(OP_INSERT_START, 10'd0, 12'd3, 8'd0, 12'd0));
        send_request(request(OP_INSERT_BYTE, 10'd0, 12'd0, 8'h00, 12'd0));
        send_request(request(OP_INSERT_BYTE, 10'd0, 12'd0, 8'hFF, 12'd0));
        send_request(request(OP_INSERT_BYTE, 10'd0, 12'd0, 8'hA5, 12'd0));
        send_request(request(OP_INSERT_BYTE, 10'd0, 12'd0, 8'h5A, 12'd0));
        send_request(request(OP_READ_SIZE, 10'd1, 12'd0, 8'd0, 12'd0));
        send_request(request(OP_READ_BYTE, 10'd1, 12'd0, 8'd0, 12'd2));
        send_request(request(OP_READ_BYTE, 10'd0, 12'd0, 8'd0, 12'd0));
        send_request(request(OP_READ_SIZE, 10'd2, 12'd0, 8'd0, 12'd0));
    endtask

    // Delete twice, read a deleted slot, reuse the lowest deleted slot,
    // abandon a row halfway.
    task automatic test_delete_reuse();
        send_request(request(OP_DELETE, 10'd1, 12'd0, 8'd0, 12'd0));
        send_request(request(OP_DELETE, 10'd1, 12'd0, 8'd0, 12'd0));
        send_request(request(OP_READ_SIZE, 10'd1, 12'd0, 8'd0, 12'd0));
        send_request(request(OP_DELETE, 10'd0, 12'd0, 8'd0, 12'd0));
        send_request(request(OP_INSERT_START, 10'd0, 12'd1, 8'd0, 12'd0));
        send_request(request(OP_INSERT_BYTE, 10'd0, 12'd0, 8'h3C, 12'd0));
        send_request(request(OP_INSERT_START, 10'd0, 12'd4, 8'd0, 12'd0));
        send_request(request(OP_INSERT_BYTE, 10'd0, 12'd0, 8'hC3, 12'd0));
        send_request(request(OP_INSERT_START, 10'd0, 12'd0, 8'd0, 12'd0));
        send_request(request(OP_READ_BYTE, 10'd1, 12'd0, 8'd0, safe_index(10'd1, 12'd0)));
    endtask

    // Mostly whole rows with random content, some abandoned, with reads
    // mixed into the fill; stretches alternate between idling and none.
    task automatic test_random_traffic();
        int unsigned pick;
        int unsigned len;
        int unsigned fill;
        page_req_t r;
        while (beats_sent < RANDOM_TARGET) begin
            gaps_on = ((beats_sent / GAP_STRETCH) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                r   = random_fields(OP_INSERT_START);
                len = ($urandom_range(0, 99) < 3) ? $urandom_range(20, 120)
                                                  : $urandom_range(0, 10);
                r.row_length = 12'(len);
                send_request(r);
                fill = ($urandom_range(0, 99) < 15) ? $urandom_range(0, len) : len;
                repeat (fill) begin
                    if ($urandom_range(0, 7) == 0)
                        send_request(random_lookup(OP_READ_BYTE));
                    send_request(random_fields(OP_INSERT_BYTE));
                end
            end else if (pick < 55) begin
                send_request(random_lookup(OP_DELETE));
            end else if (pick < 75) begin
                send_request(random_lookup(OP_READ_SIZE));
            end else if (pick < 95) begin
                send_request(random_lookup(OP_READ_BYTE));
            end else if (pick < 98) begin
                send_request(random_fields(OP_INSERT_BYTE));
            end else begin
                send_request(random_fields(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST))));
            end
        end
    endtask

    // Space check at its edge: one byte too many is refused, the exact
    // fit is taken into a reused slot, and then a row of zero bytes is
    // refused although a deleted slot is free.
    task automatic test_page_full();
        int unsigned gap;
        gaps_on = 1'b1;
        send_request(request(OP_DELETE, 10'd0, 12'd0, 8'd0, 12'd0));
        gap = free_hi - free_lo;
        if (gap >= 8) begin
            if (gap - 7 <= 4095)
                send_request(request(OP_INSERT_START, 10'd0, 12'(gap - 7), 8'd0, 12'd0));
            send_request(request(OP_INSERT_START, 10'd0, 12'(gap - 8), 8'd0, 12'd0));
            repeat (3)
                send_request(random_fields(OP_INSERT_BYTE));
            send_request(request(OP_READ_SIZE, 10'd0, 12'd0, 8'd0, 12'd0));
            send_request(request(OP_READ_BYTE, 10'd0, 12'd0, 8'd0, safe_index(10'd0, 12'd1)));
            send_request(request(OP_READ_BYTE, 10'd0, 12'd0, 8'd0, 12'hFFF));
        end
        send_request(request(OP_DELETE, 10'd1, 12'd0, 8'd0, 12'd0));
        send_request(request(OP_INSERT_START, 10'd0, 12'd0, 8'd0, 12'd0));
        send_request(request(OP_INSERT_START, 10'd0, 12'hFFF, 8'd0, 12'd0));
        send_request(random_fields(OP_INSERT_BYTE));
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_page();
        test_insert_and_read();
        test_delete_reuse();
        test_random_traffic();
        test_page_full();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        // catch any stray result beat
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d request beats and %0d result beats, %0d mismatches.",
                 beats_sent, results_seen, error_count);
        $display("Rows stored %0d, inserts refused for space %0d, slots in directory %0d.",
                 rows_stored, rows_refused, slot_total);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
